>>> hw/rtl/lksc_pkg.sv
package lksc_pkg;

	typedef enum logic [1:0] {
		CMD_GET   = 2'd0,
		CMD_FAIL  = 2'd1,
		CMD_PUT   = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	localparam logic [7:0] ACCEPTED_SIZE = 8'd48;
	localparam int         SLOT_OUT_BITS = 5;

	typedef struct packed {
		logic valid;
		logic hit;
		logic free_found;
		logic loaded;
		logic failed;
		logic requested;
	} tok_flags_t;

	typedef struct packed {
		logic valid;
		logic alloc;
		logic stamp_we;
		logic set_loaded;
		logic set_failed;
		logic set_requested;
		logic clear_all;
	} upd_t;

endpackage

>>> hw/rtl/lksc_cell.sv
module lksc_cell
	import lksc_pkg::*;
#(
	parameter int KEY_BITS   = 64,
	parameter int STAMP_BITS = 32,
	parameter int IDX_W      = 5,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [KEY_BITS-1:0]   lookup_key,
	input  upd_t                  upd,
	input  logic [IDX_W-1:0]      upd_idx,
	input  logic [STAMP_BITS-1:0] upd_stamp,
	input  tok_flags_t            tok_in,
	input  logic [IDX_W-1:0]      tok_in_hit_idx,
	input  logic [IDX_W-1:0]      tok_in_vic_idx,
	input  logic [STAMP_BITS-1:0] tok_in_vic_stamp,
	output tok_flags_t            tok_out,
	output logic [IDX_W-1:0]      tok_out_hit_idx,
	output logic [IDX_W-1:0]      tok_out_vic_idx,
	output logic [STAMP_BITS-1:0] tok_out_vic_stamp
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic                  used_q;
	logic                  loaded_q;
	logic                  failed_q;
	logic                  requested_q;
	logic [KEY_BITS-1:0]   ent_key_q;
	logic [STAMP_BITS-1:0] stamp_q;

	tok_flags_t            tok_f_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [IDX_W-1:0]      vic_idx_q;
	logic [STAMP_BITS-1:0] vic_stamp_q;

	tok_flags_t            tok_f_n;
	logic [IDX_W-1:0]      hit_idx_n;
	logic [IDX_W-1:0]      vic_idx_n;
	logic [STAMP_BITS-1:0] vic_stamp_n;

	logic hit_here;
	logic sel;

	assign hit_here = used_q && (ent_key_q == lookup_key);
	assign sel      = upd.valid && (upd_idx == MY_IDX);

	always_comb begin
		tok_f_n     = tok_in;
		hit_idx_n   = tok_in_hit_idx;
		vic_idx_n   = tok_in_vic_idx;
		vic_stamp_n = tok_in_vic_stamp;
		if (!tok_in.hit && hit_here) begin
			tok_f_n.hit       = 1'b1;
			tok_f_n.loaded    = loaded_q;
			tok_f_n.failed    = failed_q;
			tok_f_n.requested = requested_q;
			hit_idx_n         = MY_IDX;
		end
		if (!tok_in.free_found) begin
			if (!used_q) begin
				tok_f_n.free_found = 1'b1;
				vic_idx_n          = MY_IDX;
			end else if (stamp_q < tok_in_vic_stamp) begin
				vic_idx_n   = MY_IDX;
				vic_stamp_n = stamp_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_f_q <= '0;
		end else begin
			tok_f_q <= tok_f_n;
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_q   <= hit_idx_n;
		vic_idx_q   <= vic_idx_n;
		vic_stamp_q <= vic_stamp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= 1'b0;
			loaded_q    <= 1'b0;
			failed_q    <= 1'b0;
			requested_q <= 1'b0;
		end else if (upd.valid && upd.clear_all) begin
			used_q      <= 1'b0;
			loaded_q    <= 1'b0;
			failed_q    <= 1'b0;
			requested_q <= 1'b0;
		end else if (sel) begin
			if (upd.alloc) begin
				used_q      <= 1'b1;
				loaded_q    <= 1'b0;
				failed_q    <= 1'b0;
				requested_q <= 1'b0;
			end
			if (upd.set_loaded) begin
				loaded_q <= 1'b1;
				failed_q <= 1'b0;
			end
			if (upd.set_failed) begin
				failed_q <= 1'b1;
			end
			if (upd.set_requested) begin
				requested_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && !upd.clear_all) begin
			if (upd.alloc) begin
				ent_key_q <= lookup_key;
			end
			if (upd.stamp_we) begin
				stamp_q <= upd_stamp;
			end else if (upd.alloc) begin
				stamp_q <= '0;
			end
		end
	end

	assign tok_out           = tok_f_q;
	assign tok_out_hit_idx   = hit_idx_q;
	assign tok_out_vic_idx   = vic_idx_q;
	assign tok_out_vic_stamp = vic_stamp_q;

endmodule

>>> hw/rtl/lru_keyed_slot_cache.sv
// Path: a lookup token walks the cell chain, one register per slot; the update is
//   applied and the result beat registered as the token leaves the chain.
// Flow control: one item at a time; the next beat is taken once the result beat
//   has left, so a stalled output holds off the input.
// Reset: all slots empty, access tick zero, fetching disabled; no clearing pass.
module lru_keyed_slot_cache
	import lksc_pkg::*;
#(
	parameter int SLOTS      = 20,
	parameter int KEY_BITS   = 64,
	parameter int STAMP_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               command,
	input  logic [KEY_BITS-1:0]      key,
	input  logic                     want_round,
	input  logic [7:0]               image_size,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     image_ready,
	output logic [SLOT_OUT_BITS-1:0] slot_index,
	output logic                     variant,
	output logic                     fetch_request,
	output logic [KEY_BITS-1:0]      fetch_key,
	output logic                     done_res
);

	localparam int IDX_W = $clog2(SLOTS);

	state_t state_q;
	state_t state_n;

	logic                  fetch_en_q;
	logic [STAMP_BITS-1:0] tick_q;
	logic                  start_q;
	cmd_t                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic                  round_q;
	logic [7:0]            size_q;

	logic                     res_ready_q;
	logic [SLOT_OUT_BITS-1:0] res_slot_q;
	logic                     res_variant_q;
	logic                     res_fetch_q;
	logic [KEY_BITS-1:0]      res_fkey_q;
	logic                     res_done_q;

	tok_flags_t            tok_f     [SLOTS+1];
	logic [IDX_W-1:0]      tok_hit   [SLOTS+1];
	logic [IDX_W-1:0]      tok_vic   [SLOTS+1];
	logic [STAMP_BITS-1:0] tok_stamp [SLOTS+1];

	tok_flags_t            last;
	logic [IDX_W-1:0]      s_idx;
	logic [STAMP_BITS-1:0] tick_n;
	upd_t                  upd;

	logic                     r_ready;
	logic [SLOT_OUT_BITS-1:0] r_slot;
	logic                     r_variant;
	logic                     r_fetch;
	logic [KEY_BITS-1:0]      r_fkey;
	logic                     r_done;

	logic accept;

	assign accept = in_valid && !in_stall;

	always_comb begin
		tok_f[0]       = '0;
		tok_f[0].valid = start_q;
		tok_hit[0]     = '0;
		tok_vic[0]     = '0;
		tok_stamp[0]   = '1;
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		lksc_cell #(
			.KEY_BITS   (KEY_BITS),
			.STAMP_BITS (STAMP_BITS),
			.IDX_W      (IDX_W),
			.INDEX      (i)
		) u_cell (
			.clk               (clk),
			.arst_n            (arst_n),
			.lookup_key        (key_q),
			.upd               (upd),
			.upd_idx           (s_idx),
			.upd_stamp         (tick_n),
			.tok_in            (tok_f[i]),
			.tok_in_hit_idx    (tok_hit[i]),
			.tok_in_vic_idx    (tok_vic[i]),
			.tok_in_vic_stamp  (tok_stamp[i]),
			.tok_out           (tok_f[i+1]),
			.tok_out_hit_idx   (tok_hit[i+1]),
			.tok_out_vic_idx   (tok_vic[i+1]),
			.tok_out_vic_stamp (tok_stamp[i+1])
		);
	end

	assign last   = tok_f[SLOTS];
	assign s_idx  = last.hit ? tok_hit[SLOTS] : tok_vic[SLOTS];
	assign tick_n = tick_q + 1'b1;

	// decide the update and the result once the token leaves the chain
	always_comb begin
		upd       = '0;
		r_ready   = 1'b0;
		r_slot    = '0;
		r_variant = 1'b0;
		r_fetch   = 1'b0;
		r_fkey    = '0;
		r_done    = 1'b0;
		case (cmd_q)
			CMD_GET: begin
				upd.valid     = last.valid;
				upd.alloc     = !last.hit;
				upd.stamp_we  = 1'b1;
				r_ready       = last.hit && last.loaded;
				r_fetch       = !r_ready && !(last.hit && last.requested)
					&& !(last.hit && last.failed) && fetch_en_q;
				upd.set_requested = r_fetch;
				r_slot        = SLOT_OUT_BITS'(s_idx);
				r_variant     = r_ready && round_q;
				r_fkey        = r_fetch ? key_q : '0;
				r_done        = last.hit;
			end
			CMD_FAIL: begin
				if (last.hit) begin
					upd.valid      = last.valid;
					upd.set_failed = 1'b1;
					r_slot         = SLOT_OUT_BITS'(s_idx);
					r_done         = 1'b1;
				end
			end
			CMD_PUT: begin
				if (size_q == ACCEPTED_SIZE) begin
					upd.valid      = last.valid;
					upd.alloc      = !last.hit;
					upd.set_loaded = 1'b1;
					r_slot         = SLOT_OUT_BITS'(s_idx);
					r_done         = 1'b1;
				end
			end
			CMD_CLEAR: begin
				upd.valid     = last.valid;
				upd.clear_all = 1'b1;
				r_done        = 1'b1;
			end
			default: begin
				upd = '0;
			end
		endcase
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_n = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last.valid) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_stall) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_q    <= 1'b0;
			fetch_en_q <= 1'b0;
			tick_q     <= '0;
		end else begin
			state_q <= state_n;
			start_q <= accept;
			if (cfg_we) begin
				fetch_en_q <= cfg_wdata;
			end
			if (last.valid && cmd_q == CMD_GET) begin
				tick_q <= tick_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(command);
			key_q   <= key;
			round_q <= want_round;
			size_q  <= image_size;
		end
		if (last.valid) begin
			res_ready_q   <= r_ready;
			res_slot_q    <= r_slot;
			res_variant_q <= r_variant;
			res_fetch_q   <= r_fetch;
			res_fkey_q    <= r_fkey;
			res_done_q    <= r_done;
		end
	end

	assign image_ready   = res_ready_q;
	assign slot_index    = res_slot_q;
	assign variant       = res_variant_q;
	assign fetch_request = res_fetch_q;
	assign fetch_key     = res_fkey_q;
	assign done_res      = res_done_q;

endmodule

>>> dv/testbench.sv
module testbench
	import lksc_pkg::*;
();

	localparam int SLOTS       = 20;
	localparam int KEY_BITS    = 64;
	localparam int STAMP_BITS  = 32;
	localparam int POOL        = 30;
	localparam int HOLD_CYCLES = 400;
	localparam int LIMIT       = 300000;

	typedef struct packed {
		cmd_t                cmd;
		logic [KEY_BITS-1:0] key;
		logic                round;
		logic [7:0]          size;
	} beat_t;

	typedef struct packed {
		logic                     ready;
		logic [SLOT_OUT_BITS-1:0] slot;
		logic                     variant;
		logic                     freq;
		logic [KEY_BITS-1:0]      fkey;
		logic                     done;
	} reply_t;

	typedef struct {
		beat_t  b;
		bit     typed;
		reply_t r;
	} row_t;

	typedef enum int {
		STALL_NONE,
		STALL_SOME,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic                     cfg_wdata;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               command;
	logic [KEY_BITS-1:0]      key;
	logic                     want_round;
	logic [7:0]               image_size;
	logic                     out_valid;
	logic                     out_stall;
	logic                     image_ready;
	logic [SLOT_OUT_BITS-1:0] slot_index;
	logic                     variant;
	logic                     fetch_request;
	logic [KEY_BITS-1:0]      fetch_key;
	logic                     done_res;

	bit [KEY_BITS-1:0]   slot_key[SLOTS];
	bit                  slot_used[SLOTS];
	bit                  slot_loaded[SLOTS];
	bit                  slot_failed[SLOTS];
	bit                  slot_requested[SLOTS];
	bit [STAMP_BITS-1:0] slot_stamp[SLOTS];
	bit [STAMP_BITS-1:0] tick;
	bit                  fetch_on;

	reply_t            reply_q[$];
	row_t              script[$];
	logic [KEY_BITS-1:0] key_pool[POOL];

	int  burst_left   = 0;
	bit  hold_req     = 1'b0;
	int  cycle_count  = 0;
	int  n_errors     = 0;
	int  n_replies    = 0;
	int  n_gets       = 0;
	int  n_puts       = 0;
	int  n_fails      = 0;
	int  n_clears     = 0;
	int  n_fetches    = 0;
	int  n_ready      = 0;
	int  n_evictions  = 0;
	int  n_cfg_writes = 0;

	always #2 clk = ~clk;

	lru_keyed_slot_cache #(
		.SLOTS(SLOTS),
		.KEY_BITS(KEY_BITS),
		.STAMP_BITS(STAMP_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.key(key),
		.want_round(want_round),
		.image_size(image_size),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.image_ready(image_ready),
		.slot_index(slot_index),
		.variant(variant),
		.fetch_request(fetch_request),
		.fetch_key(fetch_key),
		.done_res(done_res)
	);

	function automatic void wipe_slot(int i);
		slot_key[i]       = '0;
		slot_used[i]      = 1'b0;
		slot_loaded[i]    = 1'b0;
		slot_failed[i]    = 1'b0;
		slot_requested[i] = 1'b0;
		slot_stamp[i]     = '0;
	endfunction

	function automatic int find_slot(logic [KEY_BITS-1:0] k);
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_used[i] && slot_key[i] == k)
				return i;
		end
		return -1;
	endfunction

	function automatic int claim_slot(logic [KEY_BITS-1:0] k);
		int pick;
		pick = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!slot_used[i]) begin
				pick = i;
				break;
			end
			if (slot_stamp[i] < slot_stamp[pick])
				pick = i;
		end
		if (slot_used[pick])
			n_evictions++;
		wipe_slot(pick);
		slot_used[pick] = 1'b1;
		slot_key[pick]  = k;
		return pick;
	endfunction

	function automatic reply_t predict_reply(beat_t b);
		reply_t r;
		int     s;
		r = '0;
		case (b.cmd)
			CMD_GET: begin
				n_gets++;
				tick = tick + 1'b1;
				s = find_slot(b.key);
				if (s >= 0)
					r.done = 1'b1;
				else
					s = claim_slot(b.key);
				slot_stamp[s] = tick;
				r.slot = s[SLOT_OUT_BITS-1:0];
				if (slot_loaded[s]) begin
					r.ready   = 1'b1;
					r.variant = b.round;
					n_ready++;
				end else if (!slot_requested[s] && !slot_failed[s] && fetch_on) begin
					slot_requested[s] = 1'b1;
					r.freq = 1'b1;
					r.fkey = b.key;
					n_fetches++;
				end
			end
			CMD_FAIL: begin
				n_fails++;
				s = find_slot(b.key);
				if (s >= 0) begin
					slot_failed[s] = 1'b1;
					r.slot = s[SLOT_OUT_BITS-1:0];
					r.done = 1'b1;
				end
			end
			CMD_PUT: begin
				n_puts++;
				if (b.size == ACCEPTED_SIZE) begin
					s = find_slot(b.key);
					if (s < 0)
						s = claim_slot(b.key);
					slot_loaded[s] = 1'b1;
					slot_failed[s] = 1'b0;
					r.slot = s[SLOT_OUT_BITS-1:0];
					r.done = 1'b1;
				end
			end
			default: begin
				n_clears++;
				for (int i = 0; i < SLOTS; i++)
					wipe_slot(i);
				r.done = 1'b1;
			end
		endcase
		return r;
	endfunction

	task automatic flag_error(string what, logic [KEY_BITS-1:0] got, logic [KEY_BITS-1:0] want);
		$display("mismatch on %s at reply %0d: got %h, wanted %h", what, n_replies, got, want);
		n_errors++;
	endtask

	task automatic add_row(cmd_t c, logic [KEY_BITS-1:0] k, logic rnd, logic [7:0] sz,
			bit typed, logic rdy, logic [SLOT_OUT_BITS-1:0] sl, logic vr, logic fq,
			logic [KEY_BITS-1:0] fk, logic dn);
		row_t row;
		row.b     = '{cmd: c, key: k, round: rnd, size: sz};
		row.typed = typed;
		row.r     = '{ready: rdy, slot: sl, variant: vr, freq: fq, fkey: fk, done: dn};
		script.push_back(row);
	endtask

	task automatic send_beat(beat_t b, bit typed, reply_t want);
		reply_t got;
		int     gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		command    = b.cmd;
		key        = b.key;
		want_round = b.round;
		image_size = b.size;
		in_valid   = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = predict_reply(b);
		reply_q.push_back(typed ? want : got);
	endtask

	task automatic drain_replies();
		@(negedge clk);
		in_valid = 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic apply_fetch_enable(bit v);
		drain_replies();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we   = 1'b0;
		fetch_on = v;
		n_cfg_writes++;
	endtask

	task automatic run_random(int n);
		beat_t b;
		int    sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 199);
			if (sel < 110)
				b.cmd = CMD_GET;
			else if (sel < 150)
				b.cmd = CMD_PUT;
			else if (sel < 198)
				b.cmd = CMD_FAIL;
			else
				b.cmd = CMD_CLEAR;
			if ($urandom_range(0, 99) < 85)
				b.key = key_pool[$urandom_range(0, POOL - 1)];
			else
				b.key = {$urandom, $urandom};
			b.round = 1'($urandom_range(0, 1));
			b.size  = ($urandom_range(0, 9) < 7) ? ACCEPTED_SIZE : 8'($urandom_range(0, 255));
			send_beat(b, 1'b0, '0);
		end
	endtask

	// receiver: random stall patterns, plus one long hold-off on request
	initial begin
		stall_mode_t mode;
		int          mode_left;
		out_stall = 1'b0;
		mode      = STALL_NONE;
		mode_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				for (int n = 1; n < HOLD_CYCLES; n++)
					@(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					STALL_NONE:     out_stall = 1'b0;
					STALL_SOME:     out_stall = ($urandom_range(0, 2) == 0);
					STALL_PERIODIC: out_stall = (mode_left % 8) < 3;
					default:        out_stall = ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_replies++;
			if (reply_q.size() == 0) begin
				flag_error("beat with nothing pending", KEY_BITS'(slot_index), '0);
			end else begin
				want = reply_q.pop_front();
				if (image_ready !== want.ready)
					flag_error("image_ready", KEY_BITS'(image_ready), KEY_BITS'(want.ready));
				if (slot_index !== want.slot)
					flag_error("slot_index", KEY_BITS'(slot_index), KEY_BITS'(want.slot));
				if (variant !== want.variant)
					flag_error("variant", KEY_BITS'(variant), KEY_BITS'(want.variant));
				if (fetch_request !== want.freq)
					flag_error("fetch_request", KEY_BITS'(fetch_request),
						KEY_BITS'(want.freq));
				if (fetch_key !== want.fkey)
					flag_error("fetch_key", fetch_key, want.fkey);
				if (done_res !== want.done)
					flag_error("done_res", KEY_BITS'(done_res), KEY_BITS'(want.done));
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timed out after %0d cycles with %0d replies pending", LIMIT, reply_q.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 1'b0;
		in_valid   = 1'b0;
		command    = CMD_GET;
		key        = '0;
		want_round = 1'b0;
		image_size = '0;

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL; i++)
			key_pool[i] = {$urandom, $urandom};

		//      cmd        key                     rnd size   typ rdy sl vr fq fkey   dn
		add_row(CMD_GET,   64'h0,                  1, 8'd0,   1,  0, 0, 0, 1, 64'h0, 0);
		add_row(CMD_GET,   '1,                     0, 8'd0,   1,  0, 1, 0, 1, '1,    0);
		add_row(CMD_GET,   '1,                     1, 8'd0,   1,  0, 1, 0, 0, 64'h0, 1);
		add_row(CMD_PUT,   '1,                     0, 8'd48,  1,  0, 1, 0, 0, 64'h0, 1);
		add_row(CMD_GET,   '1,                     1, 8'd0,   1,  1, 1, 1, 0, 64'h0, 1);
		add_row(CMD_PUT,   64'h0,                  0, 8'd47,  1,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_PUT,   64'h0,                  0, 8'd255, 1,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_PUT,   64'h0,                  0, 8'd0,   1,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_FAIL,  64'h0,                  0, 8'd0,   1,  0, 0, 0, 0, 64'h0, 1);
		add_row(CMD_FAIL,  64'h0123_4567_89ab_cdef, 1, 8'd48, 1,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_GET,   64'h0,                  0, 8'd0,   0,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_PUT,   64'h0,                  1, 8'd48,  0,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_PUT,   64'h5,                  0, 8'd48,  0,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_GET,   64'h5,                  0, 8'd0,   0,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_FAIL,  64'h5,                  0, 8'd0,   0,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_CLEAR, 64'h0,                  0, 8'd0,   1,  0, 0, 0, 0, 64'h0, 1);
		add_row(CMD_GET,   64'ha5a5_a5a5_5a5a_5a5a, 1, 8'd0,  0,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_FAIL,  64'ha5a5_a5a5_5a5a_5a5a, 0, 8'd0,  0,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_GET,   64'ha5a5_a5a5_5a5a_5a5a, 0, 8'd0,  0,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_PUT,   64'ha5a5_a5a5_5a5a_5a5a, 0, 8'd48, 0,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_GET,   64'ha5a5_a5a5_5a5a_5a5a, 1, 8'd0,  0,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_GET,   64'h8000_0000_0000_0001, 0, 8'd0,  0,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_PUT,   64'h7fff_ffff_ffff_fffe, 1, 8'd48, 0,  0, 0, 0, 0, 64'h0, 0);
		add_row(CMD_GET,   64'h7fff_ffff_ffff_fffe, 1, 8'd0,  0,  0, 0, 0, 0, 64'h0, 0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		apply_fetch_enable(1'b1);
		foreach (script[i])
			send_beat(script[i].b, script[i].typed, script[i].r);

		apply_fetch_enable(1'b0);
		run_random(120);

		// long hold-off on the result side while beats keep coming
		apply_fetch_enable(1'b1);
		hold_req = 1'b1;
		run_random(140);

		apply_fetch_enable(1'b0);
		run_random(60);

		apply_fetch_enable(1'b1);
		run_random(80);

		drain_replies();
		repeat (SLOTS + 8) @(posedge clk);

		$display("ran %0d get, %0d put, %0d mark-failed and %0d clear commands, %0d replies",
			n_gets, n_puts, n_fails, n_clears, n_replies);
		$display("saw %0d fetch requests, %0d ready hits, %0d evictions, %0d fetch-enable writes",
			n_fetches, n_ready, n_evictions, n_cfg_writes);
		if (n_errors == 0 && reply_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
